// ----- hw/rtl/ycc420_pkg.sv -----
package ycc420_pkg;

    // Field and port widths.
    localparam int COMP_W      = 8;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int COUNT_W     = 12;
    localparam int COORD_W     = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    // Line store geometry.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);

    // Video range limits and the chroma offset.
    localparam logic [COMP_W-1:0] YC_MIN   = 8'd16;
    localparam logic [COMP_W-1:0] Y_MAX    = 8'd235;
    localparam logic [COMP_W-1:0] C_MAX    = 8'd240;
    localparam logic [COMP_W-1:0] C_OFFSET = 8'd128;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic [COMP_W-1:0] cb;
        logic [COMP_W-1:0] cr;
    } chroma_t;

    // Position of one pixel and its frame-edge flags.
    typedef struct packed {
        logic [COUNT_W-1:0] col;
        logic [COUNT_W-1:0] row;
        logic               last_col;
        logic               last_row;
    } pos_t;

    // Saturates a 9-bit value into lo..hi.
    function automatic logic [COMP_W-1:0] clamp8(input logic [COMP_W:0] v,
                                                 input logic [COMP_W-1:0] lo,
                                                 input logic [COMP_W-1:0] hi);
        logic [COMP_W-1:0] res;
        if (v < {1'b0, lo})
            res = lo;
        else if (v > {1'b0, hi})
            res = hi;
        else
            res = v[COMP_W-1:0];
        return res;
    endfunction

endpackage

// ----- hw/rtl/ycc420_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module ycc420_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ycc420_convert.sv -----
// Shift-add BT.601 color conversion of one pixel with saturation.
module ycc420_convert (
    input  logic [ycc420_pkg::COMP_W-1:0] red,
    input  logic [ycc420_pkg::COMP_W-1:0] green,
    input  logic [ycc420_pkg::COMP_W-1:0] blue,
    output logic [ycc420_pkg::COMP_W-1:0] luma,
    output ycc420_pkg::chroma_t           chroma
);

    logic [15:0]        y_sum;
    logic signed [17:0] r_s;
    logic signed [17:0] g_s;
    logic signed [17:0] b_s;
    logic signed [17:0] cb_sum;
    logic signed [17:0] cr_sum;
    logic signed [17:0] offset_s;
    logic [8:0]         y_raw;

    assign r_s      = $signed({10'd0, red});
    assign g_s      = $signed({10'd0, green});
    assign b_s      = $signed({10'd0, blue});
    assign offset_s = $signed({2'd0, ycc420_pkg::C_OFFSET, 8'd0});

    // The luma sum stays below 2^16 for any input.
    assign y_sum = 16'(red) * 16'd66 + 16'(green) * 16'd129 + 16'(blue) * 16'd25;
    assign y_raw = 9'(y_sum[15:8]) + 9'(ycc420_pkg::YC_MIN);

    // With the offset added the chroma sums are positive and below 2^16, so
    // bits 15:8 give 128 plus the floored quotient.
    assign cb_sum = offset_s + b_s * 18'sd112 - r_s * 18'sd38 - g_s * 18'sd74;
    assign cr_sum = offset_s + r_s * 18'sd112 - g_s * 18'sd94 - b_s * 18'sd18;

    assign luma = ycc420_pkg::clamp8(y_raw, ycc420_pkg::YC_MIN, ycc420_pkg::Y_MAX);
    assign chroma.cb = ycc420_pkg::clamp8({1'b0, cb_sum[15:8]}, ycc420_pkg::YC_MIN,
                                          ycc420_pkg::C_MAX);
    assign chroma.cr = ycc420_pkg::clamp8({1'b0, cr_sum[15:8]}, ycc420_pkg::YC_MIN,
                                          ycc420_pkg::C_MAX);

endmodule

// ----- hw/rtl/ycc420_average.sv -----
// Chroma averaging over the 2x2 block or an edge pair, and the emit decision.
module ycc420_average (
    input  ycc420_pkg::pos_t              pos,
    input  ycc420_pkg::chroma_t           here,
    input  ycc420_pkg::chroma_t           left,
    input  ycc420_pkg::chroma_t           up,
    input  ycc420_pkg::chroma_t           upleft,
    output logic                          emit,
    output logic [ycc420_pkg::COMP_W-1:0] cb_avg,
    output logic [ycc420_pkg::COMP_W-1:0] cr_avg
);

    logic       col_odd;
    logic       row_odd;
    logic [9:0] cb_quad;
    logic [9:0] cr_quad;
    logic [8:0] cb_left;
    logic [8:0] cr_left;
    logic [8:0] cb_up;
    logic [8:0] cr_up;

    assign col_odd = pos.col[0];
    assign row_odd = pos.row[0];

    assign cb_quad = 10'(here.cb) + 10'(left.cb) + 10'(up.cb) + 10'(upleft.cb);
    assign cr_quad = 10'(here.cr) + 10'(left.cr) + 10'(up.cr) + 10'(upleft.cr);
    assign cb_left = 9'(here.cb) + 9'(left.cb);
    assign cr_left = 9'(here.cr) + 9'(left.cr);
    assign cb_up   = 9'(here.cb) + 9'(up.cb);
    assign cr_up   = 9'(here.cr) + 9'(up.cr);

    always_comb
    begin
        emit   = 1'b0;
        cb_avg = cb_quad[9:2];
        cr_avg = cr_quad[9:2];
        if (row_odd && col_odd)
        begin
            emit = 1'b1;
        end
        else if (pos.last_row && col_odd)
        begin
            // Bottom row of an odd-height frame: pair with the left pixel.
            emit   = 1'b1;
            cb_avg = cb_left[8:1];
            cr_avg = cr_left[8:1];
        end
        else if (pos.last_col && row_odd)
        begin
            // Right column of an odd-width frame: pair with the pixel above.
            emit   = 1'b1;
            cb_avg = cb_up[8:1];
            cr_avg = cr_up[8:1];
        end
    end

endmodule

// ----- hw/rtl/rgb_to_ycbcr_420_downsample_core.sv -----
// RGB to YCbCr 4:2:0 converter. Pixels arrive in raster order, one item per
// clock, and each is converted with BT.601 shift-add coefficients (luma held
// to 16..235, chroma to 16..240). At every odd row and odd column one item
// leaves with that pixel's luma, chroma averaged over the 2x2 block and the
// coordinates halved; on the last row of an odd-height frame or the last
// column of an odd-width frame chroma is averaged over an edge pair instead,
// and the bottom-right pixel of an odd-by-odd frame produces nothing. The
// block sustains one input item per clock while the output is not stalled.
// The input register and the line store read are loaded at the edge that
// accepts a pixel; the converted pixel is registered in the converted
// stage and the averaged item in the output register. Chroma of even rows
// is kept in a 4096 x 16 line store that is not cleared after reset and
// needs no clearing pass. frame_width and frame_height take effect at once
// and should be written only while the block is idle; the pixel counters
// are not reset by a write.
module rgb_to_ycbcr_420_downsample_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [ycc420_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ycc420_pkg::CFG_W-1:0]          cfg_data,
    // Pixel input.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [ycc420_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Subsampled output.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // luma [7:0], chroma_blue [15:8], chroma_red [23:16], out_col [34:24],
    // out_row [45:35], zeros [47:46]
    output logic [ycc420_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int CW = ycc420_pkg::COMP_W;

    // Configuration and pixel counters.
    logic [ycc420_pkg::CFG_W-1:0]   width_reg, width_next;
    logic [ycc420_pkg::CFG_W-1:0]   height_reg, height_next;
    logic [ycc420_pkg::COUNT_W-1:0] col_reg, col_next;
    logic [ycc420_pkg::COUNT_W-1:0] row_reg, row_next;
    logic [ycc420_pkg::CFG_W-1:0]   width_last;
    logic [ycc420_pkg::CFG_W-1:0]   height_last;
    logic                           col_wrap;
    logic                           row_wrap;
    ycc420_pkg::pos_t               pos_in;

    // Input stage.
    logic                           s1_valid_reg, s1_valid_next;
    logic [CW-1:0]                  s1_red_reg;
    logic [CW-1:0]                  s1_green_reg;
    logic [CW-1:0]                  s1_blue_reg;
    ycc420_pkg::pos_t               s1_pos_reg;
    logic                           byp_valid_reg;
    ycc420_pkg::chroma_t            byp_data_reg;

    // Converted stage.
    logic                           s2_valid_reg, s2_valid_next;
    logic [CW-1:0]                  s2_luma_reg;
    ycc420_pkg::chroma_t            s2_here_reg;
    ycc420_pkg::chroma_t            s2_left_reg;
    ycc420_pkg::chroma_t            s2_up_reg;
    ycc420_pkg::chroma_t            s2_upleft_reg;
    ycc420_pkg::pos_t               s2_pos_reg;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    logic [CW-1:0]                  out_luma_reg;
    logic [CW-1:0]                  out_cb_reg;
    logic [CW-1:0]                  out_cr_reg;
    logic [ycc420_pkg::COORD_W-1:0] out_col_reg;
    logic [ycc420_pkg::COORD_W-1:0] out_row_reg;

    logic                           accept;
    logic                           en1;
    logic                           en2;
    logic                           en_out;
    logic [CW-1:0]                  conv_luma;
    ycc420_pkg::chroma_t            conv_chroma;
    ycc420_pkg::chroma_t            line_rdata;
    ycc420_pkg::chroma_t            up_word;
    logic                           line_we;
    logic                           emit;
    logic [CW-1:0]                  avg_cb;
    logic [CW-1:0]                  avg_cr;

    // A stage moves on when the one after it has room. A stage holding an
    // item that produces no result empties without touching the output.
    assign en_out   = !out_valid_reg || m_tready;
    assign en2      = !s2_valid_reg || !emit || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;

    // Frame sizes out of range are treated as the nearest legal size.
    always_comb
    begin
        if (width_reg == '0)
            width_last = '0;
        else if (width_reg > ycc420_pkg::CFG_W'(ycc420_pkg::MAX_WIDTH))
            width_last = ycc420_pkg::CFG_W'(ycc420_pkg::MAX_WIDTH - 1);
        else
            width_last = width_reg - 1'b1;

        if (height_reg == '0)
            height_last = '0;
        else if (height_reg > ycc420_pkg::CFG_W'(ycc420_pkg::MAX_HEIGHT))
            height_last = ycc420_pkg::CFG_W'(ycc420_pkg::MAX_HEIGHT - 1);
        else
            height_last = height_reg - 1'b1;
    end

    assign col_wrap = {1'b0, col_reg} >= width_last;
    assign row_wrap = {1'b0, row_reg} >= height_last;

    assign pos_in.col      = col_reg;
    assign pos_in.row      = row_reg;
    assign pos_in.last_col = {1'b0, col_reg} == width_last;
    assign pos_in.last_row = {1'b0, row_reg} == height_last;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ycc420_pkg::REG_FRAME_WIDTH:  width_next  = cfg_data;
                ycc420_pkg::REG_FRAME_HEIGHT: height_next = cfg_data;
                default:                      ;
            endcase
        end

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        s1_valid_next  = en1 ? accept : s1_valid_reg;
        s2_valid_next  = en2 ? s1_valid_reg : s2_valid_reg;
        out_valid_next = en_out ? (s2_valid_reg && emit) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= ycc420_pkg::WIDTH_RESET;
            height_reg    <= ycc420_pkg::HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The line store is read at the accepted pixel's column; the data is
    // ready while that pixel sits in the input stage and holds until the
    // next accept. Even-row chroma is written as a pixel leaves the input
    // stage. In a one-pixel-wide frame that write can land on the same edge
    // as the read for the pixel below, so the written word is then kept in
    // a bypass register and used in place of the stale read data.
    assign line_we = s1_valid_reg && en2 && !s1_pos_reg.row[0];
    assign up_word = byp_valid_reg ? byp_data_reg : line_rdata;

    ycc420_ram #(
        .WIDTH ($bits(ycc420_pkg::chroma_t)),
        .DEPTH (ycc420_pkg::MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_pos_reg.col[ycc420_pkg::LINE_AW-1:0]),
        .wdata (conv_chroma),
        .re    (accept),
        .raddr (col_reg[ycc420_pkg::LINE_AW-1:0]),
        .rdata (line_rdata)
    );

    ycc420_convert u_convert (
        .red    (s1_red_reg),
        .green  (s1_green_reg),
        .blue   (s1_blue_reg),
        .luma   (conv_luma),
        .chroma (conv_chroma)
    );

    ycc420_average u_average (
        .pos    (s2_pos_reg),
        .here   (s2_here_reg),
        .left   (s2_left_reg),
        .up     (s2_up_reg),
        .upleft (s2_upleft_reg),
        .emit   (emit),
        .cb_avg (avg_cb),
        .cr_avg (avg_cr)
    );

    // Payload registers. The left neighbor is the chroma of the previous
    // pixel, and the upper-left neighbor is the line store word fetched for
    // the previous pixel, both still held in the converted stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red_reg    <= s_tdata[7:0];
            s1_green_reg  <= s_tdata[15:8];
            s1_blue_reg   <= s_tdata[23:16];
            s1_pos_reg    <= pos_in;
            byp_valid_reg <= line_we && (s1_pos_reg.col == col_reg);
            byp_data_reg  <= conv_chroma;
        end
        if (s1_valid_reg && en2)
        begin
            s2_luma_reg   <= conv_luma;
            s2_here_reg   <= conv_chroma;
            s2_left_reg   <= s2_here_reg;
            s2_up_reg     <= up_word;
            s2_upleft_reg <= s2_up_reg;
            s2_pos_reg    <= s1_pos_reg;
        end
        if (en_out && s2_valid_reg && emit)
        begin
            out_luma_reg <= s2_luma_reg;
            out_cb_reg   <= avg_cb;
            out_cr_reg   <= avg_cr;
            out_col_reg  <= s2_pos_reg.col[ycc420_pkg::COUNT_W-1:1];
            out_row_reg  <= s2_pos_reg.row[ycc420_pkg::COUNT_W-1:1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_row_reg, out_col_reg, out_cr_reg, out_cb_reg,
                       out_luma_reg};

endmodule

// ----- hw/rtl/ycc420_checker.sv -----
// Port-level checks for the 4:2:0 converter.
module ycc420_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [ycc420_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // With nothing waiting at the output, the pipeline always has room.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:0] >= ycc420_pkg::YC_MIN &&
                     m_tdata[7:0] <= ycc420_pkg::Y_MAX)
        else $error("luma out of video range");

    a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:8] >= ycc420_pkg::YC_MIN &&
                     m_tdata[15:8] <= ycc420_pkg::C_MAX &&
                     m_tdata[23:16] >= ycc420_pkg::YC_MIN &&
                     m_tdata[23:16] <= ycc420_pkg::C_MAX &&
                     m_tdata[47:46] == 2'b00)
        else $error("chroma out of video range or padding not zero");

endmodule

bind rgb_to_ycbcr_420_downsample_core ycc420_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/tb.sv -----
// Testbench for the RGB to YCbCr 4:2:0 converter.
//
// An initial block fills a queue of RGB pixels, frame by frame, and changes
// the frame size only while the block is idle. A clocked driver offers those
// pixels on the slave stream, and for every pixel that is accepted it runs the
// color conversion and 2x2 or edge-pair chroma averaging in software, pushing the expected
// subsampled item onto a queue. A clocked monitor pops that queue for every
// item accepted on the master stream and compares all fields.
module tb;

    localparam int COMP_W      = ycc420_pkg::COMP_W;
    localparam int COORD_W     = ycc420_pkg::COORD_W;
    localparam int CFG_W       = ycc420_pkg::CFG_W;
    localparam int CFG_IDX_W   = ycc420_pkg::CFG_IDX_W;
    localparam int IN_TDATA_W  = ycc420_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = ycc420_pkg::OUT_TDATA_W;
    localparam int MAX_WIDTH   = ycc420_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT  = ycc420_pkg::MAX_HEIGHT;
    localparam int YC_LO       = int'(ycc420_pkg::YC_MIN);
    localparam int Y_HI        = int'(ycc420_pkg::Y_MAX);
    localparam int C_HI        = int'(ycc420_pkg::C_MAX);

    // Cycles that pass after the last expected item before a register write.
    // A pixel passes the input stage and the converted stage before the output
    // register, so this leaves ample margin for a trailing pixel that produces nothing.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PIXELS = 1450;
    localparam int PRINT_LIMIT   = 30;

    typedef ycc420_pkg::chroma_t chroma_t;

    // Pixel as it travels on s_tdata, red in the lowest byte.
    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
    } rgb_t;

    // Subsampled item as it travels on m_tdata, luma in the lowest byte.
    typedef struct packed {
        logic [1:0]         pad;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic [COMP_W-1:0]  chroma_red;
        logic [COMP_W-1:0]  chroma_blue;
        logic [COMP_W-1:0]  luma;
    } ycc_out_t;

    // How the two sides hold off during a phase.
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Every input of the block starts at a known value.
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = ycc420_pkg::REG_FRAME_WIDTH;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Pixels waiting to be offered, and subsampled items waiting to arrive.
    rgb_t     rgb_q[$];
    ycc_out_t subsampled_q[$];

    idle_mode_t mode = IDLE_NONE;

    // Software copy of the block: registers, pixel position, the chroma of
    // the previous pixel and the chroma line store of the last even row.
    logic [CFG_W-1:0] frame_w_reg = ycc420_pkg::WIDTH_RESET;
    logic [CFG_W-1:0] frame_h_reg = ycc420_pkg::HEIGHT_RESET;
    int               col_cnt = 0;
    int               row_cnt = 0;
    chroma_t          left_cc;
    chroma_t          line_mem [MAX_WIDTH];

    int cycle_cnt = 0;
    int mismatches = 0;
    int pixels_in = 0;
    int results_seen = 0;
    int reg_writes = 0;

    rgb_to_ycbcr_420_downsample_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    // A size register of 0 acts as 1, and one above the maximum as the maximum.
    function automatic int frame_dim(input logic [CFG_W-1:0] v, input int limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic logic [COMP_W-1:0] saturate(input int v, input int lo, input int hi);
        if (v < lo)
            return lo[COMP_W-1:0];
        if (v > hi)
            return hi[COMP_W-1:0];
        return v[COMP_W-1:0];
    endfunction

    // Converts one accepted pixel, updates the software state and, at the
    // positions where the block emits, queues the subsampled item.
    task automatic convert_pixel(input rgb_t px);
        int         r = int'(px.red);
        int         g = int'(px.green);
        int         b = int'(px.blue);
        int         w = frame_dim(frame_w_reg, MAX_WIDTH);
        int         h = frame_dim(frame_h_reg, MAX_HEIGHT);
        int         col = col_cnt;
        int         row = row_cnt;
        bit         col_odd = col[0];
        bit         row_odd = row[0];
        bit         emit = 1'b0;
        int         sum_cb = 0;
        int         sum_cr = 0;
        chroma_t    here;
        chroma_t    up;
        chroma_t    upleft;
        ycc_out_t   res;

        res = '0;
        res.luma = saturate(16 + ((66 * r + 129 * g + 25 * b) >>> 8), YC_LO, Y_HI);
        // Adding 32768 before the shift gives 128 plus the floor of sum / 256.
        here.cb = saturate((-38 * r - 74 * g + 112 * b + 32768) >>> 8, YC_LO, C_HI);
        here.cr = saturate((112 * r - 94 * g - 18 * b + 32768) >>> 8, YC_LO, C_HI);

        if (row_odd && col_odd)
        begin
            // Full 2x2 block: this pixel, its left neighbor and two from above.
            up = line_mem[col];
            upleft = line_mem[col - 1];
            sum_cb = int'(here.cb) + left_cc.cb + up.cb + upleft.cb;
            sum_cr = int'(here.cr) + left_cc.cr + up.cr + upleft.cr;
            res.chroma_blue = COMP_W'(sum_cb >> 2);
            res.chroma_red = COMP_W'(sum_cr >> 2);
            emit = 1'b1;
        end
        else if (row == h - 1 && col_odd)
        begin
            // Last row of an odd-height frame pairs with the left pixel.
            sum_cb = int'(here.cb) + left_cc.cb;
            sum_cr = int'(here.cr) + left_cc.cr;
            res.chroma_blue = COMP_W'(sum_cb >> 1);
            res.chroma_red = COMP_W'(sum_cr >> 1);
            emit = 1'b1;
        end
        else if (col == w - 1 && row_odd)
        begin
            // Last column of an odd-width frame pairs with the pixel above.
            up = line_mem[col];
            sum_cb = int'(here.cb) + up.cb;
            sum_cr = int'(here.cr) + up.cr;
            res.chroma_blue = COMP_W'(sum_cb >> 1);
            res.chroma_red = COMP_W'(sum_cr >> 1);
            emit = 1'b1;
        end

        if (!row_odd)
            line_mem[col] = here;
        left_cc = here;

        if (col + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (row + 1 >= h) ? 0 : row + 1;
        end
        else
        begin
            col_cnt = col + 1;
        end

        if (emit)
        begin
            res.out_col = COORD_W'(col >> 1);
            res.out_row = COORD_W'(row >> 1);
            subsampled_q.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_result(input ycc_out_t got);
        ycc_out_t want;
        if (subsampled_q.size() == 0)
        begin
            report_mismatch($sformatf(
                "item with nothing expected: y=%0d cb=%0d cr=%0d col=%0d row=%0d",
                got.luma, got.chroma_blue, got.chroma_red, got.out_col, got.out_row));
        end
        else
        begin
            want = subsampled_q.pop_front();
            results_seen++;
            if (got !== want)
                report_mismatch($sformatf(
                    {"got y=%0d cb=%0d cr=%0d col=%0d row=%0d pad=%0d, ",
                     "want y=%0d cb=%0d cr=%0d col=%0d row=%0d"},
                    got.luma, got.chroma_blue, got.chroma_red, got.out_col,
                    got.out_row, got.pad, want.luma, want.chroma_blue,
                    want.chroma_red, want.out_col, want.out_row));
        end
    endtask

    // Driver. An offered pixel stays on the bus until it is taken; only then
    // may the next one be loaded or the bus go quiet for a gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                convert_pixel(rgb_t'(s_tdata));
                pixels_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (rgb_q.size() != 0
                    && !(mode == IDLE_SEND && $urandom_range(99) < 75)
                    && !(mode == IDLE_BOTH && $urandom_range(99) < 27))
                begin
                    s_tdata <= rgb_q.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. It checks what was accepted at this edge and then picks the
    // ready for the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result(ycc_out_t'(m_tdata));
            m_tready <= !((mode == IDLE_RECV && $urandom_range(99) < 75)
                          || (mode == IDLE_BOTH && $urandom_range(99) < 27));
        end
    end

    // Cycle count and the watchdog. A missing item shows up here, since the
    // drain below never completes while something is still expected.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels queued, %0d items still expected",
                     cycle_cnt, rgb_q.size(), subsampled_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [COMP_W-1:0] rand_comp();
        int k = $urandom_range(7);
        if (k == 0)
            return 8'h00;
        if (k == 1)
            return 8'hFF;
        return COMP_W'($urandom_range(255));
    endfunction

    task automatic push_rgb(input int r, input int g, input int b);
        rgb_t px;
        px.red = COMP_W'(r);
        px.green = COMP_W'(g);
        px.blue = COMP_W'(b);
        rgb_q.push_back(px);
    endtask

    task automatic queue_random(input int n);
        repeat (n)
            push_rgb(int'(rand_comp()), int'(rand_comp()), int'(rand_comp()));
    endtask

    // Checks at the falling edge, where every value of the cycle has settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (rgb_q.size() != 0 || s_tvalid || subsampled_q.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // The block is idle whenever this is called. The register takes the value
    // at the edge where cfg_we is first seen high, and the software copy follows at that same edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ycc420_pkg::REG_FRAME_WIDTH)
            frame_w_reg = val[CFG_W-1:0];
        else
            frame_h_reg = val[CFG_W-1:0];
        reg_writes++;
    endtask

    task automatic set_frame(input int w, input int h);
        wait_drained();
        write_reg(ycc420_pkg::REG_FRAME_WIDTH, w);
        write_reg(ycc420_pkg::REG_FRAME_HEIGHT, h);
    endtask

    // Pixels still needed to bring the position back to the top left corner.
    // A column at or past the width wraps after one more pixel, and a row at
    // or past the height wraps at the end of its line.
    function automatic int pixels_left();
        int w = frame_dim(frame_w_reg, MAX_WIDTH);
        int h = frame_dim(frame_h_reg, MAX_HEIGHT);
        int n;
        int next_row;
        if (col_cnt == 0 && row_cnt == 0)
            return 0;
        n = (col_cnt >= w) ? 1 : w - col_cnt;
        next_row = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        if (next_row != 0)
            n += (h - next_row) * w;
        return n;
    endfunction

    initial
    begin
        int random_pixels;
        int p;
        int cw;
        int ch;
        int frames;
        int n;
        int k;
        int sel;
        bit cut;

        random_pixels = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames with no idling. The 2x2 frame holds a single full 2x2
        // block. The 3x3 frame has an odd width and an odd height, so it covers
        // the edge pair above, the edge pair to the left and the corner pixel
        // that produces nothing. Colors include black, white and the pure
        // primaries, which drive luma and chroma to their extremes.
        mode = IDLE_NONE;
        set_frame(2, 2);
        push_rgb(0, 0, 0);
        push_rgb(255, 255, 255);
        push_rgb(255, 0, 0);
        push_rgb(0, 0, 255);
        set_frame(3, 3);
        push_rgb(0, 255, 0);
        push_rgb(255, 255, 0);
        push_rgb(0, 255, 255);
        push_rgb(255, 0, 255);
        push_rgb(0, 0, 255);
        push_rgb(255, 255, 0);
        push_rgb(255, 255, 255);
        push_rgb(0, 0, 0);
        push_rgb(255, 0, 0);

        // Random phases. Most use small frames; three phases hit the register
        // extremes: a one-pixel-wide frame from a width of 0, where each line
        // store word is read right after it is written, a single long row
        // from a height of 0, and an over-range width that is cut short by a
        // write mid-frame.
        p = 0;
        while (p < 12 || random_pixels < RANDOM_PIXELS)
        begin
            case (p)
                2:
                begin
                    cw = 0;
                    ch = 150;
                end
                5:
                begin
                    cw = 250;
                    ch = 0;
                end
                11:
                begin
                    cw = 8191;
                    ch = 3;
                end
                default:
                begin
                    cw = $urandom_range(20, 2);
                    ch = $urandom_range(10, 2);
                end
            endcase
            set_frame(cw, ch);
            mode = idle_mode_t'(p % 4);
            frames = (p == 2 || p == 5 || p == 11) ? 1 : $urandom_range(2, 1);
            cut = (p == 11) || ($urandom_range(3) == 0);
            n = frame_dim(CFG_W'(cw), MAX_WIDTH) * frame_dim(CFG_W'(ch), MAX_HEIGHT);

            for (int f = 0; f < frames; f++)
            begin
                if (cut && f == frames - 1)
                begin
                    // Stop inside the frame, shrink the size while the block
                    // is idle and let the counters wrap on their own.
                    k = (p == 11) ? 9 : $urandom_range(n - 1, 1);
                    queue_random(k);
                    wait_drained();
                    sel = $urandom_range(2);
                    if (sel != 1)
                        write_reg(ycc420_pkg::REG_FRAME_WIDTH,
                                  (p == 11) ? $urandom_range(16, 2)
                                            : $urandom_range(frame_dim(CFG_W'(cw),
                                                                       MAX_WIDTH), 2));
                    if (sel != 0)
                        write_reg(ycc420_pkg::REG_FRAME_HEIGHT,
                                  $urandom_range(frame_dim(CFG_W'(ch), MAX_HEIGHT), 2));
                    k += pixels_left();
                    queue_random(pixels_left());
                end
                else
                begin
                    k = n;
                    queue_random(n);
                end
                random_pixels += k;
            end
            p++;
        end

        wait_drained();
        $display("run covered %0d pixels in %0d phases and %0d register writes", pixels_in, p,
                 reg_writes);
        $display("%0d subsampled items checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ycc420_pkg.sv
hw/rtl/ycc420_ram.sv
hw/rtl/ycc420_convert.sv
hw/rtl/ycc420_average.sv
hw/rtl/rgb_to_ycbcr_420_downsample_core.sv
hw/rtl/ycc420_checker.sv
sim/tb.sv
